@@ rtl/core/age_pkg.sv @@
// Shared types and constants for the alveolar gas exchange block.
// Used by the divider, datapath, controller and top level; no dependencies.
package age_pkg;

	localparam int CONC_W  = 24;
	localparam int VOL_W   = 32;
	localparam int GAIN_W  = 32;
	localparam int CNT_W   = 11;
	localparam int SHARE_W = 11;
	localparam int K_W     = 40;
	localparam int M_W     = 51;
	localparam int D_W     = 52;
	localparam int SUM_W   = 64;
	localparam int Q_W     = 25;
	localparam int IN_W    = 208;
	localparam int OUT_W   = 96;

	localparam logic [CNT_W-1:0]  SURFACE_TOTAL   = 11'd1770;
	localparam logic [CONC_W-1:0] CONC_MAX        = 24'hFFFFFF;
	localparam logic [CONC_W-1:0] O2_CEIL_RESET   = 24'd3355443;
	localparam logic [CONC_W-1:0] CO2_FLOOR_RESET = 24'd8053064;

	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic [GAIN_W-1:0] o2_gain;
		logic [GAIN_W-1:0] co2_gain;
		logic [GAIN_W-1:0] time_step;
		logic [CONC_W-1:0] o2_ceiling;
		logic [CONC_W-1:0] co2_floor;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SHARE_DIV,
		OP_SHARE_SET,
		OP_K,
		OP_M,
		OP_D,
		OP_GAS_DIV,
		OP_GAS_APPLY,
		OP_BLOOD_DIV,
		OP_BLOOD_APPLY,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   gas;
	} dp_cmd_t;

	typedef struct packed {
		logic first;
		logic last;
		logic gas_en;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

@@ rtl/core/age_div.sv @@
// Radix-2 restoring divider: floor(dividend * 2^16 / divisor), saturated at 2^24.
// One quotient bit per cycle, 25 quotient bits per division. Uses age_pkg.
module age_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [age_pkg::SUM_W-1:0]      dividend,
	input  logic [age_pkg::VOL_W-1:0]      divisor,
	output logic                           done,
	output logic [age_pkg::Q_W-1:0]        quotient
);

	logic [age_pkg::VOL_W-1:0] rem_q;
	logic [age_pkg::VOL_W-1:0] dvs_q;
	logic [age_pkg::Q_W-1:0]   quo_q;
	logic [age_pkg::Q_W-1:0]   low_q;
	logic [4:0]                cnt_q;
	logic                      busy_q;
	logic                      sat_q;
	logic                      done_q;
	logic [age_pkg::VOL_W:0]   rem2;
	logic [age_pkg::VOL_W:0]   diff;
	logic                      ge;

	assign rem2 = {rem_q, low_q[age_pkg::Q_W-1]};
	assign ge   = rem2 >= {1'b0, dvs_q};
	assign diff = rem2 - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(age_pkg::Q_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			sat_q <= dividend[63:9] >= {23'd0, divisor};
			rem_q <= dividend[40:9];
			low_q <= {dividend[8:0], 16'd0};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[age_pkg::VOL_W-1:0] : rem2[age_pkg::VOL_W-1:0];
			quo_q <= {quo_q[age_pkg::Q_W-2:0], ge};
			low_q <= {low_q[age_pkg::Q_W-2:0], 1'b0};
		end
	end

	assign done     = done_q;
	assign quotient = (sat_q || quo_q > 25'h1000000) ? 25'h1000000 : quo_q;

endmodule

@@ rtl/core/age_datapath.sv @@
// Datapath: item registers, pass state, exchange multipliers, totals, output register.
// Uses age_pkg and age_div; driven by age_ctrl commands.
module age_datapath #(
	parameter int MAX_ALVEOLES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  age_pkg::cfg_t                 cfg,
	input  age_pkg::dp_cmd_t              cmd,
	input  logic [age_pkg::IN_W-1:0]      in_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [age_pkg::OUT_W-1:0]     out_data,
	output logic                          out_last,
	output age_pkg::dp_stat_t             stat
);

	localparam int PW = (MAX_ALVEOLES > 1) ? $clog2(MAX_ALVEOLES) : 1;

	logic [age_pkg::CONC_W-1:0]  prev_o2_q, prev_co2_q, cur_o2_q, cur_co2_q;
	logic [age_pkg::VOL_W-1:0]   vol_q, blood_vol_q;
	logic [age_pkg::CONC_W-1:0]  bld_o2_q, bld_co2_q, new_bo2_q, new_bco2_q;
	logic [age_pkg::SHARE_W-1:0] share_q;
	logic [age_pkg::SUM_W-1:0]   sum_o2_q, sum_co2_q;
	logic [age_pkg::K_W-1:0]     k_q;
	logic [age_pkg::M_W-1:0]     m_q;
	logic [age_pkg::D_W-1:0]     d_q;
	logic [PW-1:0]               pidx_q;
	logic                        last_q;
	logic                        out_valid_q, out_last_q;
	logic [age_pkg::OUT_W-1:0]   out_data_q;

	logic [age_pkg::CNT_W-1:0]   cnt_eff;
	logic                        first, last_now;
	logic [age_pkg::GAIN_W-1:0]  gain;
	logic [age_pkg::CONC_W-1:0]  grad;
	logic [63:0]                 kprod;
	logic [age_pkg::D_W-1:0]     dhi;
	logic [47:0]                 dlo;
	logic                        div_start, div_done;
	logic [age_pkg::SUM_W-1:0]   div_a;
	logic [age_pkg::VOL_W-1:0]   div_b;
	logic [age_pkg::Q_W-1:0]     q;
	logic [age_pkg::SUM_W:0]     sum_add;
	logic [age_pkg::SUM_W-1:0]   sum_sel, sum_sat;
	logic [age_pkg::CONC_W:0]    cadd;
	logic [age_pkg::CONC_W-1:0]  csub;
	logic [age_pkg::CONC_W-1:0]  add_base, sub_base;
	logic                        out_free;

	always_comb begin
		if (cfg.count == '0)
			cnt_eff = 11'd1;
		else if (32'(cfg.count) > 32'(MAX_ALVEOLES))
			cnt_eff = 11'(MAX_ALVEOLES);
		else
			cnt_eff = cfg.count;
	end

	assign first    = pidx_q == '0;
	assign last_now = (18'(pidx_q) + 18'd1) >= 18'(cnt_eff);

	assign gain = cmd.gas ? cfg.co2_gain : cfg.o2_gain;
	always_comb begin
		if (!cmd.gas)
			grad = (prev_o2_q > bld_o2_q) ? prev_o2_q - bld_o2_q : '0;
		else
			grad = (bld_co2_q > prev_co2_q) ? bld_co2_q - prev_co2_q : '0;
	end

	assign kprod = 64'(gain) * 64'(cfg.time_step);
	assign dhi   = 52'(m_q[50:24]) * 52'(grad);
	assign dlo   = 48'(m_q[23:0]) * 48'(grad);

	assign div_start = cmd.op == age_pkg::OP_SHARE_DIV || cmd.op == age_pkg::OP_GAS_DIV
		|| cmd.op == age_pkg::OP_BLOOD_DIV;

	always_comb begin
		case (cmd.op)
			age_pkg::OP_SHARE_DIV: begin
				div_a = 64'(age_pkg::SURFACE_TOTAL);
				div_b = {5'd0, cnt_eff, 16'd0};
			end
			age_pkg::OP_GAS_DIV: begin
				div_a = 64'(d_q);
				div_b = vol_q;
			end
			default: begin
				div_a = cmd.gas ? sum_co2_q : sum_o2_q;
				div_b = blood_vol_q;
			end
		endcase
	end

	age_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (q)
	);

	assign sum_sel = cmd.gas ? sum_co2_q : sum_o2_q;
	assign sum_add = {1'b0, sum_sel} + 65'(d_q);
	assign sum_sat = sum_add[age_pkg::SUM_W] ? '1 : sum_add[age_pkg::SUM_W-1:0];

	assign add_base = (cmd.op == age_pkg::OP_BLOOD_APPLY) ? bld_o2_q : cur_co2_q;
	assign sub_base = (cmd.op == age_pkg::OP_BLOOD_APPLY) ? bld_co2_q : cur_o2_q;
	always_comb begin
		cadd = 25'(add_base) + q;
		csub = (q >= 25'(sub_base)) ? '0 : 24'(25'(sub_base) - q);
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pidx_q      <= '0;
			share_q     <= age_pkg::SURFACE_TOTAL;
			sum_o2_q    <= '0;
			sum_co2_q   <= '0;
			bld_o2_q    <= '0;
			bld_co2_q   <= '0;
			blood_vol_q <= 32'd1;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == age_pkg::OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (cmd.op)
				age_pkg::OP_LOAD: begin
					last_q <= last_now;
					pidx_q <= last_now ? '0 : pidx_q + 1'b1;
					if (first) begin
						bld_o2_q    <= in_data[151:128];
						bld_co2_q   <= in_data[175:152];
						blood_vol_q <= (in_data[207:176] == '0) ? 32'd1 : in_data[207:176];
						sum_o2_q    <= '0;
						sum_co2_q   <= '0;
					end
				end
				age_pkg::OP_SHARE_SET: share_q <= q[age_pkg::SHARE_W-1:0];
				age_pkg::OP_GAS_APPLY: begin
					if (cmd.gas)
						sum_co2_q <= sum_sat;
					else
						sum_o2_q <= sum_sat;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			age_pkg::OP_LOAD: begin
				prev_o2_q  <= in_data[23:0];
				prev_co2_q <= in_data[47:24];
				cur_o2_q   <= in_data[71:48];
				cur_co2_q  <= in_data[95:72];
				vol_q      <= (in_data[127:96] == '0) ? 32'd1 : in_data[127:96];
				new_bo2_q  <= '0;
				new_bco2_q <= '0;
			end
			age_pkg::OP_K: k_q <= kprod[63:24];
			age_pkg::OP_M: m_q <= 51'(k_q) * 51'(share_q);
			age_pkg::OP_D: d_q <= dhi + 52'(dlo[47:24]);
			age_pkg::OP_GAS_APPLY: begin
				if (cmd.gas)
					cur_co2_q <= cadd[age_pkg::CONC_W] ? age_pkg::CONC_MAX
						: cadd[age_pkg::CONC_W-1:0];
				else
					cur_o2_q <= csub;
			end
			age_pkg::OP_BLOOD_APPLY: begin
				if (cmd.gas)
					new_bco2_q <= csub;
				else
					new_bo2_q <= cadd[age_pkg::CONC_W] ? age_pkg::CONC_MAX
						: cadd[age_pkg::CONC_W-1:0];
			end
			age_pkg::OP_OUT: begin
				out_data_q <= {new_bco2_q, new_bo2_q, cur_co2_q, cur_o2_q};
				out_last_q <= last_q;
			end
			default: ;
		endcase
	end

	assign stat.first    = first;
	assign stat.last     = last_q;
	assign stat.gas_en   = (d_q != '0) && (cmd.gas ? (bld_co2_q > cfg.co2_floor)
		: (bld_o2_q < cfg.o2_ceiling));
	assign stat.div_done = div_done;
	assign stat.out_free = out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

@@ rtl/core/age_ctrl.sv @@
// Controller: sequences load, share division, per-gas exchange, blood update, output.
// Uses age_pkg; commands age_datapath.
module age_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  age_pkg::dp_stat_t   stat,
	output age_pkg::dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_SHARE_DIV, S_SHARE_WAIT, S_K, S_M, S_D, S_CHECK,
		S_GAS_WAIT, S_BLOOD_DIV, S_BLOOD_WAIT, S_OUT
	} state_t;

	state_t state_q;
	logic   gas_q;

	assign in_ready = state_q == S_IDLE;
	assign cmd.gas  = gas_q;

	always_comb begin
		case (state_q)
			S_IDLE:       cmd.op = in_valid ? age_pkg::OP_LOAD : age_pkg::OP_NONE;
			S_SHARE_DIV:  cmd.op = age_pkg::OP_SHARE_DIV;
			S_SHARE_WAIT: cmd.op = stat.div_done ? age_pkg::OP_SHARE_SET : age_pkg::OP_NONE;
			S_K:          cmd.op = age_pkg::OP_K;
			S_M:          cmd.op = age_pkg::OP_M;
			S_D:          cmd.op = age_pkg::OP_D;
			S_CHECK:      cmd.op = stat.gas_en ? age_pkg::OP_GAS_DIV : age_pkg::OP_NONE;
			S_GAS_WAIT:   cmd.op = stat.div_done ? age_pkg::OP_GAS_APPLY : age_pkg::OP_NONE;
			S_BLOOD_DIV:  cmd.op = age_pkg::OP_BLOOD_DIV;
			S_BLOOD_WAIT: cmd.op = stat.div_done ? age_pkg::OP_BLOOD_APPLY : age_pkg::OP_NONE;
			S_OUT:        cmd.op = stat.out_free ? age_pkg::OP_OUT : age_pkg::OP_NONE;
			default:      cmd.op = age_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gas_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					gas_q <= 1'b0;
					if (in_valid)
						state_q <= stat.first ? S_SHARE_DIV : S_K;
				end
				S_SHARE_DIV: state_q <= S_SHARE_WAIT;
				S_SHARE_WAIT: begin
					if (stat.div_done)
						state_q <= S_K;
				end
				S_K: state_q <= S_M;
				S_M: state_q <= S_D;
				S_D: state_q <= S_CHECK;
				S_CHECK, S_GAS_WAIT: begin
					if (state_q == S_CHECK && stat.gas_en) begin
						state_q <= S_GAS_WAIT;
					end else if (state_q == S_CHECK || stat.div_done) begin
						if (!gas_q) begin
							gas_q   <= 1'b1;
							state_q <= S_K;
						end else begin
							gas_q   <= 1'b0;
							state_q <= stat.last ? S_BLOOD_DIV : S_OUT;
						end
					end
				end
				S_BLOOD_DIV: state_q <= S_BLOOD_WAIT;
				S_BLOOD_WAIT: begin
					if (stat.div_done) begin
						if (!gas_q) begin
							gas_q   <= 1'b1;
							state_q <= S_BLOOD_DIV;
						end else begin
							gas_q   <= 1'b0;
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					if (stat.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/alveolar_gas_exchange_step.sv @@
// Alveolar gas exchange step: one alveole in, one updated alveole out; the last
// alveole of a pass also carries the new blood O2/CO2 (tlast high). An item uses
// the shared bit-serial divider once for each gas with a positive exchange that the
// blood limits allow, once for the surface share on a pass's first item and once for
// each of the two blood updates on the last item. The output register lets the next
// item enter while a result waits.
module alveolar_gas_exchange_step #(
	parameter int MAX_ALVEOLES = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// alv_prev_o2, alv_prev_co2, alv_cur_o2, alv_cur_co2, alv_volume,
	// blood_o2_in, blood_co2_in, blood_volume_in
	input  logic [207:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// new_alv_o2, new_alv_co2, new_blood_o2, new_blood_co2
	output logic [95:0]  m_axis_tdata,
	// pass_done
	output logic         m_axis_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam logic [2:0] REG_COUNT     = 3'd0;
	localparam logic [2:0] REG_O2_GAIN   = 3'd1;
	localparam logic [2:0] REG_CO2_GAIN  = 3'd2;
	localparam logic [2:0] REG_TIME_STEP = 3'd3;
	localparam logic [2:0] REG_O2_CEIL   = 3'd4;
	localparam logic [2:0] REG_CO2_FLOOR = 3'd5;

	age_pkg::cfg_t     cfg_q;
	age_pkg::dp_cmd_t  cmd;
	age_pkg::dp_stat_t stat;
	logic [2:0]        reg_idx;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count      <= 11'd1;
			cfg_q.o2_gain    <= '0;
			cfg_q.co2_gain   <= '0;
			cfg_q.time_step  <= '0;
			cfg_q.o2_ceiling <= age_pkg::O2_CEIL_RESET;
			cfg_q.co2_floor  <= age_pkg::CO2_FLOOR_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_COUNT:     cfg_q.count      <= pwdata[10:0];
				REG_O2_GAIN:   cfg_q.o2_gain    <= pwdata;
				REG_CO2_GAIN:  cfg_q.co2_gain   <= pwdata;
				REG_TIME_STEP: cfg_q.time_step  <= pwdata;
				REG_O2_CEIL:   cfg_q.o2_ceiling <= pwdata[23:0];
				REG_CO2_FLOOR: cfg_q.co2_floor  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_COUNT:     prdata = 32'(cfg_q.count);
			REG_O2_GAIN:   prdata = cfg_q.o2_gain;
			REG_CO2_GAIN:  prdata = cfg_q.co2_gain;
			REG_TIME_STEP: prdata = cfg_q.time_step;
			REG_O2_CEIL:   prdata = 32'(cfg_q.o2_ceiling);
			REG_CO2_FLOOR: prdata = 32'(cfg_q.co2_floor);
			default:       prdata = '0;
		endcase
	end

	age_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	age_datapath #(
		.MAX_ALVEOLES (MAX_ALVEOLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.in_data   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.stat      (stat)
	);

	a_blood_zero_mid_pass: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[95:48] == '0)
		else $error("blood fields nonzero on a mid-pass item");

	a_one_item_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while one is in work");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == age_pkg::OP_OUT |-> stat.out_free)
		else $error("output register loaded while occupied");

endmodule
